@@ rtl/sled_pkg.sv @@
`default_nettype none
// ============================================================================
// sled_pkg: shared types, constants and microcode for the status LED driver
// Request and result layouts, register indexes, control word encoding, the
// microcode program itself and the power-of-ten table used by digit search.
// ============================================================================
package sled_pkg;

  // Number code digits shown at most, most significant first
  localparam int CODE_DIGITS = 5;

  function automatic int ipow10(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  localparam int NUM_W   = 16;
  localparam int POW_MAX = ipow10(CODE_DIGITS - 1);
  localparam int POW_W   = $clog2(POW_MAX + 1);
  localparam int CMP_W   = (POW_W > NUM_W) ? POW_W : NUM_W;
  localparam int K_W     = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [K_W-1:0] K_LAST = K_W'(CODE_DIGITS - 1);

  // Power of ten for digit position k, as a constant select
  function automatic logic [POW_W-1:0] pow10_of(input logic [K_W-1:0] k);
    logic [POW_W-1:0] r;
    logic [POW_W-1:0] p;
    r = '0;
    p = POW_W'(1);
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (k == K_W'(i)) r = p;
      p = POW_W'(p * POW_W'(10));
    end
    return r;
  endfunction

  // Configuration port
  localparam int CFG_W = 16;
  typedef enum logic [1:0] {
    CFG_LED_ENABLE,
    CFG_ACTIVE_LOW,
    CFG_DIGIT_PULSE,
    CFG_DIGIT_GAP
  } cfg_idx_t;

  localparam logic        LED_ENABLE_RST  = 1'b1;
  localparam logic        ACTIVE_LOW_RST  = 1'b1;
  localparam logic [15:0] DIGIT_PULSE_RST = 16'd400;
  localparam logic [15:0] DIGIT_GAP_RST   = 16'd500;

  // Request modes and severities
  typedef enum logic [2:0] {
    MODE_TICK,
    MODE_SEVERITY,
    MODE_CODE,
    MODE_START,
    MODE_STOP
  } mode_t;

  localparam logic [2:0] SEV_STEADY = 3'd0;
  localparam logic [2:0] SEV_NORMAL = 3'd1;
  localparam logic [2:0] SEV_CONFIG = 3'd2;

  localparam logic [12:0] HP_STEADY = 13'd5000;
  localparam logic [12:0] HP_NORMAL = 13'd1000;
  localparam logic [12:0] HP_CONFIG = 13'd500;
  localparam logic [12:0] HP_ALERT  = 13'd100;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ON,
    PH_OFF,
    PH_GAP
  } phase_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  severity;
    logic [15:0] code_number;
  } req_t;

  typedef struct packed {
    logic pin_level;
    logic led_lit;
    logic code_busy;
    logic is_running;
  } res_t;

  // Microcode
  typedef enum logic [3:0] {
    OP_NOP,
    OP_BLINK,
    OP_CODE_STEP,
    OP_SEVERITY,
    OP_CODE_INIT,
    OP_SEARCH,
    OP_DIGIT_CLR,
    OP_DIGIT_SUB,
    OP_DIGIT_SET,
    OP_START,
    OP_STOP,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_CODE_BUSY,
    C_CODE_SKIP,
    C_SEARCH_MORE,
    C_SUB_MORE,
    C_LOAD_PEND,
    C_OUT_FREE
  } cond_t;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] A_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] A_TICK   = 4'd1;
  localparam logic [PC_W-1:0] A_BLINK  = 4'd2;
  localparam logic [PC_W-1:0] A_CSTEP  = 4'd3;
  localparam logic [PC_W-1:0] A_CLOAD  = 4'd4;
  localparam logic [PC_W-1:0] A_CDONE  = 4'd5;
  localparam logic [PC_W-1:0] A_SEV    = 4'd6;
  localparam logic [PC_W-1:0] A_CODE   = 4'd7;
  localparam logic [PC_W-1:0] A_SEARCH = 4'd8;
  localparam logic [PC_W-1:0] A_LOAD   = 4'd9;
  localparam logic [PC_W-1:0] A_SUB    = 4'd10;
  localparam logic [PC_W-1:0] A_SET    = 4'd11;
  localparam logic [PC_W-1:0] A_START  = 4'd12;
  localparam logic [PC_W-1:0] A_STOP   = 4'd13;
  localparam logic [PC_W-1:0] A_EMIT   = 4'd14;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // The program: one control word per step
  function automatic ucode_t ucode_fetch(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      A_FETCH:  w = '{op: OP_NOP,       cond: C_DISPATCH,    target: A_FETCH};
      A_TICK:   w = '{op: OP_NOP,       cond: C_CODE_BUSY,   target: A_CSTEP};
      A_BLINK:  w = '{op: OP_BLINK,     cond: C_JUMP,        target: A_EMIT};
      A_CSTEP:  w = '{op: OP_CODE_STEP, cond: C_NEXT,        target: A_FETCH};
      A_CLOAD:  w = '{op: OP_NOP,       cond: C_LOAD_PEND,   target: A_LOAD};
      A_CDONE:  w = '{op: OP_NOP,       cond: C_JUMP,        target: A_EMIT};
      A_SEV:    w = '{op: OP_SEVERITY,  cond: C_JUMP,        target: A_EMIT};
      A_CODE:   w = '{op: OP_CODE_INIT, cond: C_CODE_SKIP,   target: A_EMIT};
      A_SEARCH: w = '{op: OP_SEARCH,    cond: C_SEARCH_MORE, target: A_SEARCH};
      A_LOAD:   w = '{op: OP_DIGIT_CLR, cond: C_NEXT,        target: A_FETCH};
      A_SUB:    w = '{op: OP_DIGIT_SUB, cond: C_SUB_MORE,    target: A_SUB};
      A_SET:    w = '{op: OP_DIGIT_SET, cond: C_JUMP,        target: A_EMIT};
      A_START:  w = '{op: OP_START,     cond: C_JUMP,        target: A_EMIT};
      A_STOP:   w = '{op: OP_STOP,      cond: C_JUMP,        target: A_EMIT};
      A_EMIT:   w = '{op: OP_EMIT,      cond: C_OUT_FREE,    target: A_FETCH};
      default:  w = '{op: OP_NOP,       cond: C_JUMP,        target: A_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] dispatch(input logic [2:0] mode);
    logic [PC_W-1:0] a;
    unique case (mode)
      MODE_TICK:     a = A_TICK;
      MODE_SEVERITY: a = A_SEV;
      MODE_CODE:     a = A_CODE;
      MODE_START:    a = A_START;
      MODE_STOP:     a = A_STOP;
      default:       a = A_EMIT;
    endcase
    return a;
  endfunction

  typedef struct packed {
    op_t  op;
    logic fetch;
  } ctrl_t;

  typedef struct packed {
    logic code_busy;
    logic code_skip;
    logic search_more;
    logic sub_more;
    logic load_pend;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/sled_seq.sv @@
`default_nettype none
// ============================================================================
// sled_seq: microcode sequencer
// Step counter, control word lookup and conditional jumps on datapath status.
// ============================================================================
module sled_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [2:0]        req_mode,
  input  logic              out_free,
  input  sled_pkg::status_t status,
  output sled_pkg::ctrl_t   ctrl
);
  import sled_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [PC_W-1:0] pc_inc;
  ucode_t          word;

  assign word   = ucode_fetch(pc);
  assign pc_inc = pc + PC_W'(1);

  always_comb begin
    unique case (word.cond)
      C_NEXT:        pc_next = pc_inc;
      C_JUMP:        pc_next = word.target;
      C_DISPATCH:    pc_next = req_valid ? dispatch(req_mode) : pc;
      C_CODE_BUSY:   pc_next = status.code_busy ? word.target : pc_inc;
      C_CODE_SKIP:   pc_next = status.code_skip ? word.target : pc_inc;
      C_SEARCH_MORE: pc_next = status.search_more ? word.target : pc_inc;
      C_SUB_MORE:    pc_next = status.sub_more ? word.target : pc_inc;
      C_LOAD_PEND:   pc_next = status.load_pend ? word.target : pc_inc;
      C_OUT_FREE:    pc_next = out_free ? word.target : pc;
      default:       pc_next = A_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op    = word.op;
  assign ctrl.fetch = (pc == A_FETCH);

endmodule
`default_nettype wire

@@ rtl/sled_dpath.sv @@
`default_nettype none
// ============================================================================
// sled_dpath: LED state datapath
// Settings, blink timer, number code counters and digit extraction, each
// action selected by the current control word.
// ============================================================================
module sled_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_take,
  input  sled_pkg::req_t        req,
  input  sled_pkg::ctrl_t       ctrl,
  input  logic                  cfg_we,
  input  sled_pkg::cfg_idx_t    cfg_index,
  input  logic [sled_pkg::CFG_W-1:0] cfg_data,
  output sled_pkg::status_t     status,
  output sled_pkg::res_t        res_now
);
  import sled_pkg::*;

  logic             led_enable;
  logic             active_low;
  logic [15:0]      digit_pulse;
  logic [15:0]      gap_len;
  req_t             item;
  logic             lit;
  logic [15:0]      elapsed;
  logic [12:0]      half_period;
  logic             running;
  logic [NUM_W-1:0] rem;
  logic [K_W-1:0]   k;
  logic [3:0]       pulses;
  phase_t           phase;
  logic [15:0]      phase_ticks;
  logic [3:0]       digit;
  logic             load_pend;

  logic [15:0]      elapsed_inc;
  logic [15:0]      ticks_inc;
  logic [15:0]      dur;
  logic             phase_end;
  logic [3:0]       pulses_dec;
  logic             lit_base;
  logic [12:0]      hp_sel;
  logic [POW_W-1:0] pow_k;
  logic [POW_W-1:0] pow_k1;
  logic [CMP_W-1:0] rem_ext;

  always_comb begin
    elapsed_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
    ticks_inc   = (phase_ticks == 16'hFFFF) ? phase_ticks : phase_ticks + 16'd1;
    dur         = (phase == PH_GAP) ? gap_len : digit_pulse;
    phase_end   = (ticks_inc >= dur);
    pulses_dec  = pulses - 4'd1;
    lit_base    = lit & led_enable;
    pow_k       = pow10_of(k);
    pow_k1      = pow10_of(k + K_W'(1));
    rem_ext     = CMP_W'(rem);
    priority if (item.severity == SEV_STEADY) hp_sel = HP_STEADY;
    else if (item.severity == SEV_NORMAL)     hp_sel = HP_NORMAL;
    else if (item.severity == SEV_CONFIG)     hp_sel = HP_CONFIG;
    else                                      hp_sel = HP_ALERT;
  end

  assign status.code_busy   = (phase != PH_IDLE);
  assign status.code_skip   = (phase != PH_IDLE) || (item.code_number == '0);
  assign status.search_more = (k != K_LAST) && (rem_ext >= CMP_W'(pow_k1));
  assign status.sub_more    = (rem_ext >= CMP_W'(pow_k));
  assign status.load_pend   = load_pend;

  assign res_now.pin_level  = lit ^ active_low;
  assign res_now.led_lit    = lit;
  assign res_now.code_busy  = (phase != PH_IDLE);
  assign res_now.is_running = running;

  // Latch the request payload
  always_ff @(posedge clk) begin
    if (req_take) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_enable  <= LED_ENABLE_RST;
      active_low  <= ACTIVE_LOW_RST;
      digit_pulse <= DIGIT_PULSE_RST;
      gap_len     <= DIGIT_GAP_RST;
      lit         <= LED_ENABLE_RST;
      elapsed     <= '0;
      half_period <= '0;
      running     <= 1'b0;
      rem         <= '0;
      k           <= '0;
      pulses      <= '0;
      phase       <= PH_IDLE;
      phase_ticks <= '0;
      digit       <= '0;
      load_pend   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LED_ENABLE:  led_enable  <= cfg_data[0];
          CFG_ACTIVE_LOW:  active_low  <= cfg_data[0];
          CFG_DIGIT_PULSE: digit_pulse <= cfg_data[15:0];
          CFG_DIGIT_GAP:   gap_len     <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (ctrl.op)
        OP_BLINK: begin
          if (running) begin
            if (half_period == '0) begin
              lit <= 1'b0;
            end else if (elapsed_inc > {3'b000, half_period}) begin
              elapsed <= '0;
              lit     <= ~lit_base;
            end else begin
              elapsed <= elapsed_inc;
              lit     <= lit_base;
            end
          end
        end
        OP_CODE_STEP: begin
          load_pend <= 1'b0;
          if (!phase_end) begin
            phase_ticks <= ticks_inc;
          end else begin
            phase_ticks <= '0;
            unique case (phase)
              PH_ON: begin
                lit   <= 1'b0;
                phase <= PH_OFF;
              end
              PH_OFF: begin
                pulses <= pulses_dec;
                if (pulses_dec != '0) begin
                  lit   <= 1'b1;
                  phase <= PH_ON;
                end else begin
                  phase <= PH_GAP;
                end
              end
              PH_GAP: begin
                if (k == '0) begin
                  phase <= PH_IDLE;
                end else begin
                  k         <= k - K_W'(1);
                  load_pend <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        OP_SEVERITY: begin
          half_period <= hp_sel;
          elapsed     <= '0;
          if (phase == PH_IDLE) lit <= 1'b1;
        end
        OP_CODE_INIT: begin
          if (!status.code_skip) begin
            rem <= item.code_number;
            k   <= '0;
          end
        end
        OP_SEARCH: begin
          if (status.search_more) k <= k + K_W'(1);
        end
        OP_DIGIT_CLR: begin
          digit       <= '0;
          phase_ticks <= '0;
        end
        OP_DIGIT_SUB: begin
          // Count subtractions modulo ten
          if (status.sub_more) begin
            rem   <= NUM_W'(rem_ext - CMP_W'(pow_k));
            digit <= (digit == 4'd9) ? 4'd0 : digit + 4'd1;
          end
        end
        OP_DIGIT_SET: begin
          if (digit != '0) begin
            pulses <= digit;
            lit    <= 1'b1;
            phase  <= PH_ON;
          end else begin
            pulses <= '0;
            phase  <= PH_GAP;
          end
        end
        OP_START: running <= led_enable;
        OP_STOP:  running <= 1'b0;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_on_lit: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ON) |-> lit)
    else $error("pulse on phase with LED dark");

  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_OFF) |-> !lit)
    else $error("pulse off phase with LED lit");

  a_pulses_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ON || phase == PH_OFF) |-> (pulses != '0))
    else $error("pulse phase with no pulses left");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    k <= K_LAST)
    else $error("digit position out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/status_led_blink_code_driver_core.sv @@
`default_nettype none
// ============================================================================
// status_led_blink_code_driver_core: status LED blink and number code driver
// Microcoded sequencer over a small datapath; one result per request.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  req     | in        | req_valid/req_stall  | mode, severity, code_number
//  res     | out       | res_valid/res_stall  | pin_level, led_lit, ...
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
//  One microcode step runs per cycle, so a request costs the length of its
//  path: fetch, then severity, start or stop, then emit; a tick runs tick and
//  blink while idle, or tick, code step, load check and done during a code.
//  A code start (leading-digit search) or a new digit load instead of done
//  clears the digit, subtracts once per unit and sets it. Synchronous reset
//  restores the state registers, LED lit (not item or res). A stalled result
//  stays in the output register; the sequencer waits on emit, requests stall.
//
module status_led_blink_code_driver_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  sled_pkg::req_t              req,
  output logic                        res_valid,
  input  logic                        res_stall,
  output sled_pkg::res_t              res,
  input  logic                        cfg_we,
  input  sled_pkg::cfg_idx_t          cfg_index,
  input  logic [sled_pkg::CFG_W-1:0]  cfg_data
);
  import sled_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  res_t    res_now;
  logic    out_free;
  logic    req_take;
  logic    emit;

  // Take a request only at the fetch step
  assign req_stall = !ctrl.fetch;
  assign req_take  = req_valid && ctrl.fetch;

  // Output register free when empty or being drained this cycle
  assign out_free = !res_valid || !res_stall;
  assign emit     = (ctrl.op == OP_EMIT) && out_free;

  sled_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req.mode),
    .out_free  (out_free),
    .status    (status),
    .ctrl      (ctrl)
  );

  sled_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_take  (req_take),
    .req       (req),
    .ctrl      (ctrl),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .res_now   (res_now)
  );

  // Result register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_now;
    end
  end

`ifndef ASSERT_OFF
  a_single_take: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request taken before the first finished");

  a_res_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside an emit step");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed or dropped");
`endif

endmodule
`default_nettype wire

@@ sim/status_led_blink_code_driver_core_checker.sv @@
// ============================================================================
// Status LED driver checker
// Watches the request, result and register ports, keeps its own copy of the
// LED state, expects one result per accepted request and compares each
// accepted result field by field, oldest first.
// ============================================================================
module status_led_blink_code_driver_core_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_stall,
  input  sled_pkg::req_t             req,
  input  logic                       res_valid,
  input  logic                       res_stall,
  input  sled_pkg::res_t             res,
  input  logic                       cfg_we,
  input  sled_pkg::cfg_idx_t         cfg_index,
  input  logic [sled_pkg::CFG_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending
);
  import sled_pkg::*;

  // Register copy
  logic        cfg_enable;
  logic        cfg_active_low;
  logic [15:0] cfg_pulse;
  logic [15:0] cfg_gap;

  // LED and sequencer state
  logic        lit;
  logic [15:0] blink_elapsed;
  logic [12:0] blink_half;
  logic        running;
  logic [15:0] code_value;
  logic [13:0] digit_weight;
  logic [3:0]  pulses_todo;
  phase_t      phase;
  logic [15:0] phase_count;

  res_t led_states_q[$];
  int   mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got)
      report_mismatch($sformatf("%s: expected %0b, got %0b", name, want, got));
  endtask

  function automatic void load_next_digit();
    int digit;
    digit = (digit_weight != '0) ? (int'(code_value) / int'(digit_weight)) % 10 : 0;
    phase_count = '0;
    if (digit != 0) begin
      pulses_todo = 4'(digit);
      lit = 1'b1;
      phase = PH_ON;
    end else begin
      pulses_todo = '0;
      phase = PH_GAP;
    end
  endfunction

  function automatic void advance_code();
    logic [15:0] span;
    span = (phase == PH_GAP) ? cfg_gap : cfg_pulse;
    if (phase_count != 16'hFFFF) phase_count++;
    if (phase_count >= span) begin
      phase_count = '0;
      case (phase)
        PH_ON: begin
          lit = 1'b0;
          phase = PH_OFF;
        end
        PH_OFF: begin
          pulses_todo = pulses_todo - 4'd1;
          if (pulses_todo != '0) begin
            lit = 1'b1;
            phase = PH_ON;
          end else begin
            phase = PH_GAP;
          end
        end
        default: begin
          digit_weight = digit_weight / 14'd10;
          if (digit_weight == '0) phase = PH_IDLE;
          else load_next_digit();
        end
      endcase
    end
  endfunction

  function automatic void advance_blink();
    if (!cfg_enable) lit = 1'b0;
    if (blink_half == '0) begin
      lit = 1'b0;
    end else begin
      if (blink_elapsed != 16'hFFFF) blink_elapsed++;
      if (blink_elapsed > 16'(blink_half)) begin
        blink_elapsed = '0;
        lit = ~lit;
      end
    end
  endfunction

  // Find the leading power of ten (largest at or below n) and load the first digit
  function automatic void begin_code(input logic [15:0] n);
    int weight;
    int shown;
    weight = 1;
    shown = 1;
    if (phase == PH_IDLE && n != '0) begin
      while (shown < CODE_DIGITS && int'(n) >= weight * 10) begin
        weight = weight * 10;
        shown++;
      end
      code_value = n;
      digit_weight = 14'(weight);
      load_next_digit();
    end
  endfunction

  function automatic res_t predict_led_state(input req_t r);
    case (r.mode)
      MODE_TICK: begin
        if (phase != PH_IDLE) advance_code();
        else if (running) advance_blink();
      end
      MODE_SEVERITY: begin
        case (r.severity)
          SEV_STEADY: blink_half = HP_STEADY;
          SEV_NORMAL: blink_half = HP_NORMAL;
          SEV_CONFIG: blink_half = HP_CONFIG;
          default:    blink_half = HP_ALERT;
        endcase
        blink_elapsed = '0;
        if (phase == PH_IDLE) lit = 1'b1;
      end
      MODE_CODE:  begin_code(r.code_number);
      MODE_START: running = cfg_enable;
      MODE_STOP:  running = 1'b0;
      default: ;
    endcase
    return '{pin_level: lit ^ cfg_active_low, led_lit: lit,
             code_busy: phase != PH_IDLE, is_running: running};
  endfunction

  function automatic void restore_reset_state();
    cfg_enable     = LED_ENABLE_RST;
    cfg_active_low = ACTIVE_LOW_RST;
    cfg_pulse      = DIGIT_PULSE_RST;
    cfg_gap        = DIGIT_GAP_RST;
    lit            = LED_ENABLE_RST;
    blink_elapsed  = '0;
    blink_half     = '0;
    running        = 1'b0;
    code_value     = '0;
    digit_weight   = '0;
    pulses_todo    = '0;
    phase          = PH_IDLE;
    phase_count    = '0;
    led_states_q.delete();
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      restore_reset_state();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LED_ENABLE:  cfg_enable     = cfg_data[0];
          CFG_ACTIVE_LOW:  cfg_active_low = cfg_data[0];
          CFG_DIGIT_PULSE: cfg_pulse      = cfg_data;
          CFG_DIGIT_GAP:   cfg_gap        = cfg_data;
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (led_states_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = led_states_q.pop_front();
          check_field("pin_level",  want.pin_level,  res.pin_level);
          check_field("led_lit",    want.led_lit,    res.led_lit);
          check_field("code_busy",  want.code_busy,  res.code_busy);
          check_field("is_running", want.is_running, res.is_running);
        end
      end
      if (req_valid && !req_stall) led_states_q.push_back(predict_led_state(req));
    end
    errors  <= mismatch_count;
    pending <= led_states_q.size();
  end

endmodule

@@ sim/status_led_blink_code_driver_core_tb.sv @@
// ============================================================================
// Status LED driver testbench
// Drives ticks, severity messages, number codes and start/stop requests into
// the core under a series of register settings, with random gaps on the
// request side and random stalls on the result side; the checker beside the
// core predicts every result and counts mismatches.
// ============================================================================
module status_led_blink_code_driver_core_tb;
  import sled_pkg::*;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int SETTLE_CYCLES     = 40;
  localparam int ITEMS_PER_SETTING = 100;

  // Request modes the core leaves alone, and severities that map to alert
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [2:0] SEV_ALERT_FIRST  = 3'd3;
  localparam logic [2:0] SEV_ALERT_LAST   = 3'd7;

  logic             clk;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req       = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_t             res;
  logic             cfg_we    = 1'b0;
  cfg_idx_t         cfg_index = CFG_LED_ENABLE;
  logic [CFG_W-1:0] cfg_data  = '0;

  int errors;
  int pending;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_ticks   = 0;

  status_led_blink_code_driver_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  status_led_blink_code_driver_core_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, at the current receiver idle rate
  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Give up on a run that hangs: a lost result or a wedged sequencer
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic req_t make_request(input logic [2:0] m, input logic [2:0] s,
                                        input logic [15:0] n);
    return '{mode: m, severity: s, code_number: n};
  endfunction

  // Mostly ticks, so that codes run to the end and the blink timer gets to
  // toggle; now and then an alert message opens a long run of ticks only.
  // Fields that a mode ignores still carry random noise.
  function automatic req_t next_random_request();
    req_t r;
    int   pick;
    r.mode        = MODE_TICK;
    r.severity    = 3'($urandom_range(0, 7));
    r.code_number = 16'($urandom_range(0, 65535));
    pick          = $urandom_range(0, 99);
    if (quiet_ticks > 0) begin
      quiet_ticks--;
    end else if (pick < 82) begin
      r.mode = MODE_TICK;
    end else if (pick < 86) begin
      r.mode = MODE_SEVERITY;
      if ($urandom_range(0, 9) == 0) begin
        r.severity = 3'($urandom_range(SEV_ALERT_FIRST, SEV_ALERT_LAST));
        quiet_ticks = $urandom_range(101, 160);
      end
    end else if (pick < 91) begin
      r.mode = MODE_CODE;
      // Lean on powers of ten, zero, short codes and codes with zero digits
      case ($urandom_range(0, 4))
        0: r.code_number = 16'(10 ** $urandom_range(0, CODE_DIGITS - 1));
        1: r.code_number = '0;
        2: r.code_number = 16'($urandom_range(1, 99));
        3: r.code_number = 16'($urandom_range(100, 9999));
        default: ;
      endcase
    end else if (pick < 95) begin
      r.mode = MODE_START;
    end else if (pick < 97) begin
      r.mode = MODE_STOP;
    end else begin
      r.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    end
    return r;
  endfunction

  // Hold valid low for a random gap, then present the request and hold it
  // until the core takes it. Valid stays high afterwards, so back-to-back
  // requests never lower and raise it within one step.
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid, wait for every outstanding result, then let the sequencer
  // run out its longest path before touching anything else
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges while the core is idle
  task automatic apply_setting(input logic en, input logic al,
                               input logic [15:0] pulse, input logic [15:0] gap);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LED_ENABLE;
    cfg_data  <= CFG_W'(en);
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_LOW;
    cfg_data  <= CFG_W'(al);
    @(posedge clk);
    cfg_index <= CFG_DIGIT_PULSE;
    cfg_data  <= pulse;
    @(posedge clk);
    cfg_index <= CFG_DIGIT_GAP;
    cfg_data  <= gap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random requests in three stretches: fast sender with a busy receiver,
  // the reverse, then both sides flat out
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i < count / 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 83;
      end else if (i < 2 * count / 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_request(next_random_request());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset register values
    send_request(make_request(MODE_TICK, SEV_STEADY, 16'h0000));
    send_request(make_request(MODE_START, SEV_STEADY, 16'h0000));
    // No half-period yet: a running tick holds the LED off
    send_request(make_request(MODE_TICK, SEV_STEADY, 16'h0000));
    send_request(make_request(MODE_SEVERITY, SEV_STEADY, 16'hFFFF));
    send_request(make_request(MODE_TICK, SEV_ALERT_LAST, 16'hFFFF));
    send_request(make_request(MODE_SEVERITY, SEV_NORMAL, 16'h0000));
    send_request(make_request(MODE_SEVERITY, SEV_CONFIG, 16'h0000));
    send_request(make_request(MODE_SEVERITY, SEV_ALERT_FIRST, 16'h0000));
    send_request(make_request(MODE_SEVERITY, SEV_ALERT_LAST, 16'h0000));
    // Zero blinks nothing; an exact power of ten finds its leading digit
    send_request(make_request(MODE_CODE, SEV_STEADY, 16'd0));
    send_request(make_request(MODE_CODE, SEV_STEADY, 16'd10000));
    // A second code while one runs is dropped
    send_request(make_request(MODE_CODE, SEV_ALERT_LAST, 16'hFFFF));
    // A message during a code leaves the LED to the code
    send_request(make_request(MODE_SEVERITY, SEV_NORMAL, 16'h0000));
    send_request(make_request(MODE_TICK, SEV_STEADY, 16'h0000));
    send_request(make_request(MODE_TICK, SEV_STEADY, 16'h0000));
    // Code progress carries on while stopped
    send_request(make_request(MODE_STOP, SEV_STEADY, 16'h0000));
    send_request(make_request(MODE_TICK, SEV_STEADY, 16'h0000));
    send_request(make_request(MODE_SEVERITY, SEV_CONFIG, 16'h0000));
    send_request(make_request(MODE_START, SEV_STEADY, 16'h0000));
    send_request(make_request(MODE_SPARE_FIRST, SEV_ALERT_LAST, 16'hFFFF));
    send_request(make_request(3'(MODE_SPARE_FIRST + 3'd1), SEV_STEADY, 16'h5555));
    send_request(make_request(MODE_SPARE_LAST, SEV_NORMAL, 16'hAAAA));
    send_request(make_request(MODE_TICK, SEV_STEADY, 16'h0000));

    // Shortest durations, so that digits and gaps come round quickly
    apply_setting(1'b1, 1'b0, 16'd1, 16'd1);
    run_random(ITEMS_PER_SETTING);
    apply_setting(1'b1, 1'b1, 16'd2, 16'd3);
    run_random(ITEMS_PER_SETTING);
    // Disable while the block may be running: ticks hold the LED off but light
    // it on a blink toggle, and start requests clear the running flag
    apply_setting(1'b0, 1'b0, 16'd3, 16'd2);
    run_random(ITEMS_PER_SETTING);
    // Longest durations: any code in progress sits in its current phase
    apply_setting(1'b1, 1'b0, 16'hFFFF, 16'hFFFF);
    run_random(ITEMS_PER_SETTING);
    // Zero durations behave as one tick
    apply_setting(1'b1, 1'b1, 16'd0, 16'd0);
    run_random(ITEMS_PER_SETTING);
    apply_setting(1'b0, 1'b1, 16'd1, 16'd5);
    run_random(ITEMS_PER_SETTING);
    apply_setting(1'b1, 1'b0, 16'd4, 16'd1);
    run_random(ITEMS_PER_SETTING);

    settle();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
